@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// concurrent assertion forms for the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define OFI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication, off while reset is held
`define OFI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

// next-cycle implication that also holds across reset
`define OFI_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("next-cycle implication across reset failed");

`endif

@@ rtl/ofi_pkg.sv @@
// ---------------------------------------------------------------------------
// ofi_pkg
// types and constants shared by the order flow imbalance accumulator
// ---------------------------------------------------------------------------
`default_nettype none

package ofi_pkg;

  localparam int TIME_W     = 48;
  localparam int PRICE_W    = 32;
  localparam int SIZE_W     = 32;
  localparam int SUM_W      = 64;
  localparam int INTERVAL_W = 40;
  // one side's delta needs 33 bits, the difference of two sides needs 34
  localparam int DELTA_W    = 34;

  localparam int IN_TDATA_W  = 176;
  localparam int OUT_TDATA_W = 176;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 40'd1000000000;
  localparam logic [SUM_W-1:0]      SUM_MAX      = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]      SUM_MIN      = {1'b1, {(SUM_W-1){1'b0}}};

  // top-of-book update, last field in the lowest bits
  typedef struct packed {
    logic [SIZE_W-1:0]  ask_size;
    logic [PRICE_W-1:0] ask_price;
    logic [SIZE_W-1:0]  bid_size;
    logic [PRICE_W-1:0] bid_price;
    logic [TIME_W-1:0]  time_ns;
  } ofi_in_t;

  // emitted feature row, last field in the lowest bits
  typedef struct packed {
    logic signed [SUM_W-1:0] flow_imbalance;
    logic [PRICE_W-1:0]      row_ask_price;
    logic [PRICE_W-1:0]      row_bid_price;
    logic [TIME_W-1:0]       row_time_ns;
  } ofi_out_t;

endpackage

`default_nettype wire

@@ rtl/ofi_in_skid.sv @@
// ---------------------------------------------------------------------------
// ofi_in_skid
// input register with skid entry, ready toward the source is registered
// ---------------------------------------------------------------------------
`default_nettype none

module ofi_in_skid (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ofi_pkg::ofi_in_t in_item,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output ofi_pkg::ofi_in_t     out_item
);
  import ofi_pkg::*;

  logic    main_valid_r, main_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  ofi_in_t main_r, main_nxt;
  ofi_in_t skid_r, skid_nxt;
  logic    accept;
  logic    take;

  assign in_ready  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_item  = main_r;

  assign accept = in_valid && !skid_valid_r;
  assign take   = main_valid_r && out_ready;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (!main_valid_r || take) begin
      // main slot frees up: refill from skid first, else from the input
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        main_nxt       = in_item;
        main_valid_nxt = accept;
      end
    end else if (accept) begin
      skid_nxt       = in_item;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/ofi_core.sv @@
// ---------------------------------------------------------------------------
// ofi_core
// per-update imbalance delta, saturating running sum, emit decision, result register
// ---------------------------------------------------------------------------
`default_nettype none

module ofi_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [ofi_pkg::INTERVAL_W-1:0]     interval,
  input  wire logic                               item_valid,
  output logic                                    item_ready,
  input  wire ofi_pkg::ofi_in_t                   item,
  output logic                                    row_valid,
  input  wire logic                               row_ready,
  output ofi_pkg::ofi_out_t                       row
);
  import ofi_pkg::*;

  logic [PRICE_W-1:0]      last_bid_price_r;
  logic [SIZE_W-1:0]       last_bid_size_r;
  logic [PRICE_W-1:0]      last_ask_price_r;
  logic [SIZE_W-1:0]       last_ask_size_r;
  logic                    have_last_r;
  logic [SUM_W-1:0]        ofi_sum_r, ofi_sum_nxt;
  logic [TIME_W-1:0]       last_emit_r;
  logic                    row_valid_r;
  ofi_out_t                row_r;

  logic signed [DELTA_W-1:0] bid_cur, bid_old, ask_cur, ask_old;
  logic signed [DELTA_W-1:0] e_bid, e_ask, delta;
  logic [SUM_W:0]            sum_ext;
  logic [SUM_W-1:0]          sum_sat;
  logic [SUM_W-1:0]          sum_new;
  logic [TIME_W-1:0]         time_diff;
  logic                      upd_ok;
  logic                      emit_due;
  logic                      do_emit;
  logic                      row_free;
  logic                      fire;

  assign bid_cur = $signed({{(DELTA_W-SIZE_W){1'b0}}, item.bid_size});
  assign bid_old = $signed({{(DELTA_W-SIZE_W){1'b0}}, last_bid_size_r});
  assign ask_cur = $signed({{(DELTA_W-SIZE_W){1'b0}}, item.ask_size});
  assign ask_old = $signed({{(DELTA_W-SIZE_W){1'b0}}, last_ask_size_r});

  // bid side: a higher bid adds its size, a lower bid removes the old size
  always_comb begin
    if (item.bid_price > last_bid_price_r) begin
      e_bid = bid_cur;
    end else if (item.bid_price == last_bid_price_r) begin
      e_bid = bid_cur - bid_old;
    end else begin
      e_bid = -bid_old;
    end
  end

  // ask side mirrors the bid side with the price order reversed
  always_comb begin
    if (item.ask_price < last_ask_price_r) begin
      e_ask = ask_cur;
    end else if (item.ask_price == last_ask_price_r) begin
      e_ask = ask_cur - ask_old;
    end else begin
      e_ask = -ask_old;
    end
  end

  assign delta   = e_bid - e_ask;
  assign sum_ext = {ofi_sum_r[SUM_W-1], ofi_sum_r}
                 + {{(SUM_W+1-DELTA_W){delta[DELTA_W-1]}}, delta};

  always_comb begin
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_sat = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end
  end

  // first valid update only primes the previous book
  assign sum_new = have_last_r ? sum_sat : ofi_sum_r;

  // an earlier timestamp is always due to emit, caught by its own compare
  assign time_diff = item.time_ns - last_emit_r;
  assign emit_due  = (last_emit_r == '0) || (item.time_ns < last_emit_r)
                  || (time_diff >= {{(TIME_W-INTERVAL_W){1'b0}}, interval});

  assign upd_ok   = (item.bid_price != '0) && (item.ask_price != '0);
  assign do_emit  = upd_ok && emit_due;
  assign row_free = !row_valid_r || row_ready;
  assign item_ready = !do_emit || row_free;
  assign fire     = item_valid && item_ready;

  assign ofi_sum_nxt = do_emit ? '0 : sum_new;

  assign row_valid = row_valid_r;
  assign row       = row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_bid_price_r <= '0;
      last_bid_size_r  <= '0;
      last_ask_price_r <= '0;
      last_ask_size_r  <= '0;
      have_last_r      <= 1'b0;
      ofi_sum_r        <= '0;
      last_emit_r      <= '0;
      row_valid_r      <= 1'b0;
    end else begin
      if (fire && upd_ok) begin
        last_bid_price_r <= item.bid_price;
        last_bid_size_r  <= item.bid_size;
        last_ask_price_r <= item.ask_price;
        last_ask_size_r  <= item.ask_size;
        have_last_r      <= 1'b1;
        ofi_sum_r        <= ofi_sum_nxt;
      end
      if (fire && do_emit) begin
        last_emit_r <= item.time_ns;
        row_valid_r <= 1'b1;
      end else if (row_ready) begin
        row_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && do_emit) begin
      row_r.row_time_ns    <= item.time_ns;
      row_r.row_bid_price  <= item.bid_price;
      row_r.row_ask_price  <= item.ask_price;
      row_r.flow_imbalance <= sum_new;
    end
  end

endmodule

`default_nettype wire

@@ rtl/order_flow_imbalance_accumulator_top.sv @@
// ---------------------------------------------------------------------------
// order_flow_imbalance_accumulator_top: top-of-book updates in, ofi rows out
// path: an accepted update passes the input register, then the row register
// throughput: one update per cycle, set by the state update loop, unless an emitting update waits on a full row
// reset: synchronous active-low rst_n clears book, sum and emit time,
// and returns the emit interval to 1000000000 ns
// ---------------------------------------------------------------------------
`default_nettype none

module order_flow_imbalance_accumulator_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // update items
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // time_ns[47:0], bid_price[79:48], bid_size[111:80],
  // ask_price[143:112], ask_size[175:144]
  input  wire logic [ofi_pkg::IN_TDATA_W-1:0]    in_tdata,
  // feature row items
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // row_time_ns[47:0], row_bid_price[79:48], row_ask_price[111:80],
  // flow_imbalance[175:112]
  output logic [ofi_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // emit interval register write
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ofi_pkg::INTERVAL_W-1:0]    cfg_data
);
  import ofi_pkg::*;

  // emit interval, to be written only while the block is idle; the block itself leaves this unchecked
  logic [INTERVAL_W-1:0] interval_r;

  ofi_in_t  in_item;
  ofi_in_t  core_item;
  logic     core_valid;
  logic     core_ready;
  ofi_out_t row;

  // the register write is always taken in the cycle it is offered
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RST;
    end else if (cfg_valid) begin
      interval_r <= cfg_data;
    end
  end

  // tdata is laid out exactly like the packed item struct
  assign in_item = ofi_in_t'(in_tdata);

  // input side: registered ready, a second entry catches the item in flight
  ofi_in_skid u_in_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .out_valid (core_valid),
    .out_ready (core_ready),
    .out_item  (core_item)
  );

  // book compare, saturating sum and emit decision in one pass; the core
  // stalls only an item that emits while its row register is still full
  ofi_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .interval   (interval_r),
    .item_valid (core_valid),
    .item_ready (core_ready),
    .item       (core_item),
    .row_valid  (out_tvalid),
    .row_ready  (out_tready),
    .row        (row)
  );

  assign out_tdata = OUT_TDATA_W'(row);

endmodule

`default_nettype wire

@@ rtl/ofi_checker.sv @@
// ---------------------------------------------------------------------------
// ofi_checker
// port-level checks on the accumulator, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ofi_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic [ofi_pkg::IN_TDATA_W-1:0]    in_tdata,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [ofi_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input wire logic                              cfg_valid,
  input wire logic                              cfg_ready,
  input wire logic [ofi_pkg::INTERVAL_W-1:0]    cfg_data
);
  import ofi_pkg::*;

  logic unused_ok;
  assign unused_ok = ^{in_tdata, cfg_valid, cfg_ready, cfg_data};

  // a stalled row holds
  `OFI_ASSERT_NXT(a_row_hold, clk, rst_n, out_tvalid && !out_tready,
                  out_tvalid && $stable(out_tdata))

  // no row right after reset
  `OFI_ASSERT_NXT_ALWAYS(a_row_reset, clk, !rst_n, !out_tvalid)

  // input side only backs up after taking an item
  `OFI_ASSERT_IMP(a_ready_drop, clk, rst_n, $fell(in_tready), $past(in_tvalid))

  // only updates with both sides present produce rows
  `OFI_ASSERT_IMP(a_row_prices, clk, rst_n, out_tvalid,
                  (out_tdata[79:48] != '0) && (out_tdata[111:80] != '0))

endmodule

bind order_flow_imbalance_accumulator_top ofi_checker u_ofi_checker (.*);

`default_nettype wire
